/* rtl/core/wbst_pkg.sv */
// Shared types, codes and signature tables of the beacon signature tracker.
package wbst_pkg;

    localparam int NAME_MAX_DEF   = 32;
    localparam int WINDOW_LEN_DEF = 12;

    localparam int HIT_SLOTS = 8;
    localparam int SLOT_W    = $clog2(HIT_SLOTS);
    localparam int CNT_W     = $clog2(HIT_SLOTS + 1);
    localparam int ADDR_W    = 48;
    localparam int PFX_W     = 24;
    localparam int HITS_W    = 16;
    localparam int TOTAL_W   = 32;

    // longest name signature, in bytes
    localparam int SIG_LEN    = 12;
    localparam int FIXED_PATS = 5;
    localparam int BODY_PATS  = 9;
    localparam int FIXED_PFXS = 20;
    localparam int BODY_PFXS  = 3;

    localparam logic [7:0] CHAR_END    = 8'h00;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic {
        REQ_CHAR  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_type;

    typedef enum logic {
        KIND_FIXED = 1'b0,
        KIND_BODY  = 1'b1
    } t_cam_kind;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_NEW  = 2'd1,
        ST_UPD  = 2'd2,
        ST_FULL = 2'd3
    } t_tbl_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [7:0]         name_char;
        logic               char_last;
        logic [ADDR_W-1:0]  station_address;
        logic signed [7:0]  signal_strength;
        logic [31:0]        time_ms;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        t_cam_kind          cam_type;
        t_tbl_status        table_status;
        logic [SLOT_W-1:0]  slot_index;
        logic [HITS_W-1:0]  slot_hits;
        logic [CNT_W-1:0]   entry_count;
        logic [TOTAL_W-1:0] total_found;
    } t_out_item;

    typedef struct packed {
        logic fixed_seen;
        logic body_seen;
    } t_name_flags;

    typedef struct packed {
        logic              hit;
        t_cam_kind         kind;
        logic [ADDR_W-1:0] address;
    } t_tbl_req;

    // Signature bytes, first character in the top byte, zero padded.
    localparam logic [SIG_LEN*8-1:0] FIXED_SIG [FIXED_PATS] = '{
        96'h666c6f63_6b000000_00000000,
        96'h66732065_78740000_00000000,
        96'h70696776_6973696f_6e000000,
        96'h70656e67_75696e00_00000000,
        96'h666c6f63_6b636100_00000000
    };
    localparam int FIXED_LEN [FIXED_PATS] = '{5, 6, 9, 7, 7};

    localparam logic [SIG_LEN*8-1:0] BODY_SIG [BODY_PATS] = '{
        96'h61786f6e_00000000_00000000,
        96'h62776376_69657765_72000000,
        96'h65766964_656e6365_00000000,
        96'h74617365_72000000_00000000,
        96'h6d6f746f_726f6c61_20627763,
        96'h76696576_75000000_00000000,
        96'h76333030_00000000_00000000,
        96'h76353030_00000000_00000000,
        96'h69627200_00000000_00000000
    };
    localparam int BODY_LEN [BODY_PATS] = '{4, 9, 8, 5, 12, 5, 4, 4, 3};

    localparam logic [PFX_W-1:0] FIXED_PFX [FIXED_PFXS] = '{
        24'h0017F2, 24'h001DC9, 24'h180F76, 24'h2002AF, 24'h24A43C,
        24'h2CCF67, 24'h34E894, 24'h3C5AB4, 24'h409F38, 24'h44D9E7,
        24'h482C6A, 24'h50C7BF, 24'h54AF97, 24'h5CBAEF, 24'h6038E0,
        24'h6C4008, 24'h703ACB, 24'h74DA38, 24'h788A20, 24'h7C1EB3
    };
    localparam logic [PFX_W-1:0] BODY_PFX [BODY_PFXS] = '{
        24'h0025DF, 24'h0017F2, 24'hB4E62D
    };

    // recent[8*k +: 8] is the k-th newest name byte.
    function automatic logic sig_hit(input logic [SIG_LEN*8-1:0] recent,
                                     input logic [SIG_LEN*8-1:0] sig,
                                     input int len);
        logic ok;
        ok = (len > 0);
        for (int j = 0; j < SIG_LEN; j++) begin
            if (j < len) begin
                if (recent[8*(len-1-j) +: 8] != sig[8*(SIG_LEN-1-j) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/core/wbst_if.sv */
// Valid/ready channel interfaces for input and result items.
interface wbst_in_if import wbst_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wbst_out_if import wbst_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/wbst_name_match.sv */
// Name byte window, case folding and substring signature flags.
module wbst_name_match import wbst_pkg::*; #(
    parameter int NAME_MAX   = NAME_MAX_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic        i_last,
    input  logic [7:0]  i_char,
    output t_name_flags o_flags
);

    localparam int TAKEN_W = $clog2(NAME_MAX + 1);

    logic [7:0]           r_win [WINDOW_LEN];
    logic [7:0]           n_win [WINDOW_LEN];
    logic [TAKEN_W-1:0]   r_taken;
    logic [TAKEN_W-1:0]   n_taken;
    logic                 r_ended;
    logic                 n_ended;
    t_name_flags          r_flags;
    logic                 open_slot;
    logic                 push;
    logic [7:0]           folded;
    logic [SIG_LEN*8-1:0] recent;
    logic                 fixed_hit;
    logic                 body_hit;

    always_comb begin
        open_slot = !r_ended && (r_taken < TAKEN_W'(NAME_MAX));
        push      = open_slot && (i_char != CHAR_END);
        folded    = ((i_char >= CHAR_UP_A) && (i_char <= CHAR_UP_Z)) ?
                    (i_char + CASE_OFFSET) : i_char;

        n_win[0] = folded;
        for (int k = 1; k < WINDOW_LEN; k++) begin
            n_win[k] = r_win[k-1];
        end
        for (int k = 0; k < SIG_LEN; k++) begin
            recent[8*k +: 8] = n_win[k];
        end

        fixed_hit = 1'b0;
        for (int p = 0; p < FIXED_PATS; p++) begin
            fixed_hit = fixed_hit | sig_hit(recent, FIXED_SIG[p], FIXED_LEN[p]);
        end
        body_hit = 1'b0;
        for (int p = 0; p < BODY_PATS; p++) begin
            body_hit = body_hit | sig_hit(recent, BODY_SIG[p], BODY_LEN[p]);
        end

        o_flags.fixed_seen = r_flags.fixed_seen | (push & fixed_hit);
        o_flags.body_seen  = r_flags.body_seen  | (push & body_hit);

        n_taken = push ? (r_taken + 1'b1) : r_taken;
        n_ended = r_ended | (open_slot && (i_char == CHAR_END));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_taken <= '0;
            r_ended <= 1'b0;
            r_flags <= '0;
        end else if (i_take) begin
            if (i_last) begin
                // record done: start the next name from scratch
                for (int k = 0; k < WINDOW_LEN; k++) begin
                    r_win[k] <= '0;
                end
                r_taken <= '0;
                r_ended <= 1'b0;
                r_flags <= '0;
            end else begin
                if (push) begin
                    r_win <= n_win;
                end
                r_taken <= n_taken;
                r_ended <= n_ended;
                r_flags <= o_flags;
            end
        end
    end

endmodule

/* rtl/core/wbst_hit_table.sv */
// Detection table: address lookup, insert, saturating hit counts and total.
module wbst_hit_table import wbst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_clr,
    input  logic      i_upd,
    input  t_tbl_req  i_req,
    output t_out_item o_res
);

    logic [ADDR_W-1:0]  r_addr [HIT_SLOTS];
    logic [HITS_W-1:0]  r_cnt  [HIT_SLOTS];
    logic [CNT_W-1:0]   r_filled;
    logic [CNT_W-1:0]   n_filled;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               found;
    logic [SLOT_W-1:0]  found_idx;
    logic [HITS_W-1:0]  cur_cnt;
    logic [HITS_W-1:0]  new_cnt;
    logic [SLOT_W-1:0]  ins_idx;
    logic               full;
    logic               do_ins;

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < HIT_SLOTS; i++) begin
            if (!found && (CNT_W'(i) < r_filled) && (r_addr[i] == i_req.address)) begin
                found     = 1'b1;
                found_idx = SLOT_W'(i);
            end
        end
        cur_cnt = r_cnt[found_idx];
        new_cnt = (cur_cnt != {HITS_W{1'b1}}) ? (cur_cnt + 1'b1) : cur_cnt;
        full    = (r_filled == CNT_W'(HIT_SLOTS));
        ins_idx = r_filled[SLOT_W-1:0];
        do_ins  = i_req.hit && !found && !full;

        n_filled = do_ins ? (r_filled + 1'b1) : r_filled;
        n_total  = (do_ins && (r_total != {TOTAL_W{1'b1}})) ? (r_total + 1'b1) : r_total;

        o_res.matched     = i_req.hit;
        o_res.cam_type    = i_req.hit ? i_req.kind : KIND_FIXED;
        o_res.entry_count = n_filled;
        o_res.total_found = n_total;
        if (!i_req.hit) begin
            o_res.table_status = ST_NONE;
            o_res.slot_index   = '0;
            o_res.slot_hits    = '0;
        end else if (found) begin
            o_res.table_status = ST_UPD;
            o_res.slot_index   = found_idx;
            o_res.slot_hits    = new_cnt;
        end else if (full) begin
            o_res.table_status = ST_FULL;
            o_res.slot_index   = '0;
            o_res.slot_hits    = '0;
        end else begin
            o_res.table_status = ST_NEW;
            o_res.slot_index   = ins_idx;
            o_res.slot_hits    = HITS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_total  <= '0;
        end else if (i_clr) begin
            r_filled <= '0;
            r_total  <= '0;
        end else if (i_upd) begin
            r_filled <= n_filled;
            r_total  <= n_total;
        end
    end

    // slot contents: only filled slots are ever compared or read
    always_ff @(posedge i_clk) begin
        if (i_upd && i_req.hit) begin
            if (found) begin
                r_cnt[found_idx] <= new_cnt;
            end else if (!full) begin
                r_addr[ins_idx] <= i_req.address;
                r_cnt[ins_idx]  <= HITS_W'(1);
            end
        end
    end

endmodule

/* rtl/core/wifi_beacon_signature_tracker_unit.sv */
// Top level of the beacon signature tracker: input stage, prefix match, result stage.
//
// Usage: each scanned network arrives on i_in as a run of items, one name byte per
// item, with char_last set on the final byte; the station address is taken from that
// final item. req_type = clear empties the detection table and the running total,
// yields no result and leaves a name in progress untouched.
// Every item with char_last set (and req_type = name byte) yields exactly one result
// on o_out: match flag, camera type, table status, slot, hit count, filled slot count
// and saturating total. Other items yield nothing.
// Timing: an item is held in the input register, where the name window, the prefix
// tables and the eight-slot address compare are evaluated; once the result register
// is free, its result is captured there and shown on o_out.
// Throughput: one item per cycle while o_out is not held; the table update happens in
// the input stage, where all state updates land.
// Stall: while o_out is held, the result register keeps its item; the input register
// still drains bytes that yield no result, and a final byte waits in it, which in turn
// drops i_in.ready only when both registers are full.
// Reset (i_rst_n low, synchronous): both stages empty, the name window, counters and
// table fill count go to zero.
module wifi_beacon_signature_tracker_unit import wbst_pkg::*; #(
    parameter int NAME_MAX   = NAME_MAX_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wbst_in_if.sink           i_in,
    wbst_out_if.source        o_out
);

    // input stage
    logic              r_s1_valid;
    t_req_type         r_s1_req;
    logic [7:0]        r_s1_char;
    logic              r_s1_last;
    logic [ADDR_W-1:0] r_s1_addr;

    // result stage
    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_fire;
    logic              s1_needs_out;
    logic              out_free;
    logic              s1_go;
    logic              name_take;
    logic              tbl_clr;
    logic              tbl_upd;
    t_name_flags       name_flags;
    t_tbl_req          tbl_req;
    t_out_item         tbl_res;
    logic [PFX_W-1:0]  pfx;
    logic              fixed_pfx_hit;
    logic              body_pfx_hit;

    // Handshake: the input stage advances unless it holds a final byte while the
    // result register is occupied and not being taken.
    always_comb begin
        s1_needs_out = r_s1_valid && (r_s1_req == REQ_CHAR) && r_s1_last;
        out_free     = !r_out_valid || o_out.ready;
        s1_go        = r_s1_valid && (!s1_needs_out || out_free);
        i_in.ready   = !r_s1_valid || s1_go;
        in_fire      = i_in.valid && i_in.ready;
        name_take    = s1_go && (r_s1_req == REQ_CHAR);
        tbl_clr      = s1_go && (r_s1_req == REQ_CLEAR);
        tbl_upd      = s1_go && s1_needs_out;
    end

    // Name signatures win over address prefixes; within each, fixed type wins.
    always_comb begin
        pfx           = r_s1_addr[ADDR_W-1 -: PFX_W];
        fixed_pfx_hit = 1'b0;
        for (int i = 0; i < FIXED_PFXS; i++) begin
            fixed_pfx_hit = fixed_pfx_hit | (pfx == FIXED_PFX[i]);
        end
        body_pfx_hit = 1'b0;
        for (int i = 0; i < BODY_PFXS; i++) begin
            body_pfx_hit = body_pfx_hit | (pfx == BODY_PFX[i]);
        end

        tbl_req.address = r_s1_addr;
        tbl_req.hit     = name_flags.fixed_seen | name_flags.body_seen |
                          fixed_pfx_hit | body_pfx_hit;
        if (name_flags.fixed_seen) begin
            tbl_req.kind = KIND_FIXED;
        end else if (name_flags.body_seen) begin
            tbl_req.kind = KIND_BODY;
        end else if (fixed_pfx_hit) begin
            tbl_req.kind = KIND_FIXED;
        end else if (body_pfx_hit) begin
            tbl_req.kind = KIND_BODY;
        end else begin
            tbl_req.kind = KIND_FIXED;
        end
    end

    wbst_name_match #(
        .NAME_MAX   (NAME_MAX),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_name (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (name_take),
        .i_last  (r_s1_last),
        .i_char  (r_s1_char),
        .o_flags (name_flags)
    );

    wbst_hit_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (tbl_clr),
        .i_upd   (tbl_upd),
        .i_req   (tbl_req),
        .o_res   (tbl_res)
    );

    // Load the input stage on acceptance, empty it when it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req  <= i_in.data.req_type;
            r_s1_char <= i_in.data.name_char;
            r_s1_last <= i_in.data.char_last;
            r_s1_addr <= i_in.data.station_address;
        end
    end

    // Capture a result when a final byte advances; drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tbl_upd) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_upd) begin
            r_out <= tbl_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // An item that yields no result never raises the result valid.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !s1_needs_out) |=> (r_out_valid == $past(r_out_valid && !o_out.ready)))
        else $error("result appeared for an item that yields none");

    // A fresh slot always starts at one hit and sits at the last filled position.
    a_new_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.table_status == ST_NEW)) |->
        ((o_out.data.slot_hits == HITS_W'(1)) &&
         (CNT_W'(o_out.data.slot_index) == (o_out.data.entry_count - 1'b1))))
        else $error("new slot result inconsistent with fill count");

    // Without a match there is no table activity in the result.
    a_no_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.matched) |->
        ((o_out.data.table_status == ST_NONE) && (o_out.data.slot_hits == '0) &&
         (o_out.data.cam_type == KIND_FIXED)))
        else $error("unmatched result carries table data");

endmodule
